// ----- design/assert_macros.svh -----
// assertion macros used by the sorted point store top level
// depends on nothing; clock and reset names follow the house convention
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, quiet during reset
`define SPST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also during reset
`define SPST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/spst_pkg.sv -----
// shared types and codes for the sorted point store
// no dependencies
package spst_pkg;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_READ_OK  = 2'd2;
   localparam logic [1:0] STATUS_BEYOND   = 2'd3;

   localparam logic [1:0] ORDER_XYZ = 2'd0;
   localparam logic [1:0] ORDER_YXZ = 2'd1;
   localparam logic [1:0] ORDER_ZXY = 2'd2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SHIFT  = 5'b00010,
      ST_PLACE  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_SEARCH = 5'b10000
   } state_type;

endpackage

// ----- design/spst_key_less.sv -----
// lexicographic key compare of two points under the selected key order
// depends on spst_pkg
module spst_key_less
   import spst_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic [1:0]             key_order,
   input  logic [COORD_WIDTH-1:0] a_x,
   input  logic [COORD_WIDTH-1:0] a_y,
   input  logic [COORD_WIDTH-1:0] a_z,
   input  logic [COORD_WIDTH-1:0] b_x,
   input  logic [COORD_WIDTH-1:0] b_y,
   input  logic [COORD_WIDTH-1:0] b_z,
   output logic                   a_less
);

   logic signed [COORD_WIDTH-1:0] a0, a1, a2, b0, b1, b2;

   always_comb begin
      case (key_order)
         ORDER_YXZ: begin
            a0 = a_y; a1 = a_x; a2 = a_z;
            b0 = b_y; b1 = b_x; b2 = b_z;
         end
         ORDER_ZXY: begin
            a0 = a_z; a1 = a_x; a2 = a_y;
            b0 = b_z; b1 = b_x; b2 = b_y;
         end
         default: begin
            a0 = a_x; a1 = a_y; a2 = a_z;
            b0 = b_x; b1 = b_y; b2 = b_z;
         end
      endcase
      if (a0 != b0) begin
         a_less = a0 < b0;
      end else if (a1 != b1) begin
         a_less = a1 < b1;
      end else begin
         a_less = a2 < b2;
      end
   end

endmodule

// ----- design/sorted_point_store.sv -----
// top level of the sorted point store: control, entry memory, result register
// depends on spst_pkg, spst_key_less and assert_macros.svh
//
//  channel   ports    handshake
//  request   req_*    start high while busy low
//  result    rsp_*    rsp_valid for one cycle, no backpressure
//  config    csr_*    csr_write_enable, taken at once
//
// insert: into an empty store the point is written at once, else a search reads up from
// entry 0, one read a cycle, and appends on top when every entry is below the new point,
// else moves the entries from the found one up by one, top first, then places the point.
// read: the entry is registered as the result; a refused insert or read beyond count is
// answered from idle. reset clears count, state, key order and rsp_valid, not the memory.
// the result is registered, so a new item is taken in the cycle it shows.
`include "assert_macros.svh"
module sorted_point_store
   import spst_pkg::*;
#(
   parameter int DEPTH       = 64,
   parameter int COORD_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_write_data,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [COORD_WIDTH-1:0]         req_x_coord,
   input  logic [COORD_WIDTH-1:0]         req_y_coord,
   input  logic [COORD_WIDTH-1:0]         req_z_coord,
   input  logic [7:0]                     req_red,
   input  logic [7:0]                     req_green,
   input  logic [7:0]                     req_blue,
   input  logic [31:0]                    req_point_id,
   input  logic [$clog2(DEPTH)-1:0]       req_read_index,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [$clog2(DEPTH)-1:0]       rsp_position,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_entry_count,
   output logic [COORD_WIDTH-1:0]         rsp_out_x,
   output logic [COORD_WIDTH-1:0]         rsp_out_y,
   output logic [COORD_WIDTH-1:0]         rsp_out_z,
   output logic [7:0]                     rsp_out_red,
   output logic [7:0]                     rsp_out_green,
   output logic [7:0]                     rsp_out_blue,
   output logic [31:0]                    rsp_out_id
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = 3 * COORD_WIDTH + 56;
   localparam int CWD = COORD_WIDTH;

   // entry layout: id, red, green, blue, z, y, x
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_ff;
   logic          mem_re, mem_we;
   logic [AW-1:0] mem_ra, mem_wa;
   logic [EW-1:0] mem_wd;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    order_ff, order_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [EW-1:0] new_ff, new_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic [EW-1:0] rsp_data_ff, rsp_data_in;

   logic          accept, full, ek_less;
   logic [AW-1:0] idx_up;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   spst_key_less #(.COORD_WIDTH(COORD_WIDTH)) u_key_less (
      .key_order (order_ff),
      .a_x       (rd_ff[CWD-1:0]),
      .a_y       (rd_ff[2*CWD-1:CWD]),
      .a_z       (rd_ff[3*CWD-1:2*CWD]),
      .b_x       (new_ff[CWD-1:0]),
      .b_y       (new_ff[2*CWD-1:CWD]),
      .b_z       (new_ff[3*CWD-1:2*CWD]),
      .a_less    (ek_less)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = (count_ff == CW'(DEPTH));
   assign idx_up = idx_ff + AW'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      order_in      = csr_write_enable ? csr_write_data : order_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      new_in        = new_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_data_in   = rsp_data_ff;
      mem_re        = 1'b0;
      mem_ra        = idx_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_up;
      mem_wd        = rd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in = {req_point_id, req_red, req_green, req_blue,
                         req_z_coord, req_y_coord, req_x_coord};
               if (req_mode == MODE_INSERT) begin
                  if (full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_FULL;
                     rsp_pos_in    = '0;
                     rsp_count_in  = count_ff;
                     rsp_data_in   = '0;
                  end else if (count_ff == '0) begin
                     mem_we        = 1'b1;
                     mem_wa        = '0;
                     mem_wd        = new_in;
                     count_in      = CW'(1);
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_INSERTED;
                     rsp_pos_in    = '0;
                     rsp_count_in  = CW'(1);
                     rsp_data_in   = '0;
                  end else begin
                     // search up from the bottom entry
                     idx_in   = '0;
                     mem_re   = 1'b1;
                     mem_ra   = idx_in;
                     state_in = ST_SEARCH;
                  end
               end else if (CW'(req_read_index) < count_ff) begin
                  mem_re   = 1'b1;
                  mem_ra   = req_read_index;
                  idx_in   = req_read_index;
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_BEYOND;
                  rsp_pos_in    = req_read_index;
                  rsp_count_in  = count_ff;
                  rsp_data_in   = '0;
               end
            end
         end
         ST_SEARCH: begin
            if (ek_less) begin
               if (CW'(idx_up) == count_ff) begin
                  // every entry is below the new point, append on top
                  mem_we        = 1'b1;
                  mem_wa        = idx_up;
                  mem_wd        = new_ff;
                  count_in      = count_ff + CW'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_INSERTED;
                  rsp_pos_in    = idx_up;
                  rsp_count_in  = count_in;
                  rsp_data_in   = '0;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_up;
                  mem_re = 1'b1;
                  mem_ra = idx_in;
               end
            end else begin
               // first entry not below the new point: move the tail up from the top
               pos_in   = idx_ff;
               idx_in   = AW'(count_ff - CW'(1));
               mem_re   = 1'b1;
               mem_ra   = idx_in;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            mem_we = 1'b1;
            mem_wa = idx_up;
            mem_wd = rd_ff;
            if (idx_ff == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               idx_in = idx_ff - AW'(1);
               mem_re = 1'b1;
               mem_ra = idx_in;
            end
         end
         ST_PLACE: begin
            mem_we        = 1'b1;
            mem_wa        = pos_ff;
            mem_wd        = new_ff;
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_INSERTED;
            rsp_pos_in    = pos_ff;
            rsp_count_in  = count_in;
            rsp_data_in   = '0;
            state_in      = ST_IDLE;
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_READ_OK;
            rsp_pos_in    = idx_ff;
            rsp_count_in  = count_ff;
            rsp_data_in   = rd_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         order_ff     <= ORDER_XYZ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_out_x       = rsp_data_ff[CWD-1:0];
   assign rsp_out_y       = rsp_data_ff[2*CWD-1:CWD];
   assign rsp_out_z       = rsp_data_ff[3*CWD-1:2*CWD];
   assign rsp_out_blue    = rsp_data_ff[3*CWD+7:3*CWD];
   assign rsp_out_green   = rsp_data_ff[3*CWD+15:3*CWD+8];
   assign rsp_out_red     = rsp_data_ff[3*CWD+23:3*CWD+16];
   assign rsp_out_id      = rsp_data_ff[3*CWD+55:3*CWD+24];

   `SPST_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "entry count beyond depth")
   `SPST_ASSERT(a_rw_apart, (mem_re && mem_we) |-> (mem_ra != mem_wa), "read and write hit same entry")
   `SPST_ASSERT(a_state_onehot, $onehot(state_ff), "state not one-hot")
   `SPST_ASSERT(a_insert_grows, (rsp_valid_in && rsp_status_in == STATUS_INSERTED) |=> (count_ff == $past(count_ff) + CW'(1)), "insert did not grow count")

endmodule
